@@ rtl/core/isp_pkg.sv @@
`default_nettype none

package isp_pkg;

   localparam int IterStages = 64;
   localparam int SqrtSteps  = 32;
   localparam int UnitSteps  = 30;

   localparam logic [31:0] STRENGTH_RESET     = 32'd65536;
   localparam logic [31:0] MIN_DISTANCE_RESET = 32'd65536;
   localparam logic        ENABLE_RESET       = 1'b1;

   localparam logic [62:0] G_CAP   = '1;
   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [1:0] {
      CSR_STRENGTH     = 2'd0,
      CSR_MIN_DISTANCE = 2'd1,
      CSR_ENABLE       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic        free_b;
      logic        free_a;
      logic [31:0] mass_b;
      logic [31:0] mass_a;
      logic [31:0] pos_b_z;
      logic [31:0] pos_b_y;
      logic [31:0] pos_b_x;
      logic [31:0] pos_a_z;
      logic [31:0] pos_a_y;
      logic [31:0] pos_a_x;
   } item_type;

   typedef struct packed {
      logic [5:0]  pad;
      logic        saturated;
      logic        active;
      logic [31:0] push_b_z;
      logic [31:0] push_b_y;
      logic [31:0] push_b_x;
      logic [31:0] push_a_z;
      logic [31:0] push_a_y;
      logic [31:0] push_a_x;
   } result_type;

   typedef struct packed {
      logic       act;
      logic       zero;
      logic       fa;
      logic       fb;
      logic       sneg;
      logic [2:0] negd;
   } flags_type;

   typedef struct packed {
      flags_type       flags;
      logic [65:0]     rem;
      logic [63:0]     num;
      logic [65:0]     c;
      logic [63:0]     q;
      logic [63:0]     x;
      logic [33:0]     srem;
      logic [31:0]     root;
      logic [2:0][31:0] v;
      logic [2:0][31:0] urem;
      logic [2:0][30:0] uq;
   } iter_type;

endpackage

`default_nettype wire

@@ rtl/core/isp_front.sv @@
`default_nettype none

module isp_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               move,
   input  wire logic               in_valid,
   input  wire isp_pkg::item_type  item,
   input  wire logic [31:0]        strength,
   input  wire logic [31:0]        min_distance,
   input  wire logic               enable,
   output logic                    out_valid,
   output isp_pkg::iter_type       out_st
);

   logic [4:0] valid_ff;
   logic [4:0] valid_in;

   logic [31:0] pa [3];
   logic [31:0] pb [3];

   logic signed [32:0] d_in [3];
   logic signed [32:0] d1_ff [3];
   isp_pkg::flags_type flags1_in, flags1_ff;
   logic [31:0] smag_in, smag1_ff, ma1_ff, mb1_ff, min1_ff;

   logic signed [65:0] sqf [3];
   logic [64:0] sq_in [3];
   logic [64:0] sq2_ff [3];
   logic [32:0] u_in [3];
   logic [32:0] u2_ff [3];
   logic [63:0] pm_in, pm2_ff, md_in, md2_ff;
   logic [31:0] mb2_ff;
   isp_pkg::flags_type flags2_ff;

   logic [65:0] d2_in, d23_ff;
   logic        e_in;
   logic [31:0] v_in [3];
   logic [31:0] v3_ff [3];
   logic [63:0] pl_in, ph_in, pl3_ff, ph3_ff, md3_ff;
   isp_pkg::flags_type flags3_ff;

   logic [63:0] vsq_in [3];
   logic [63:0] vsq4_ff [3];
   logic [65:0] c_in, c4_ff;
   logic [95:0] p_full;
   logic [94:0] p_in, p4_ff;
   logic [31:0] v4_ff [3];
   isp_pkg::flags_type flags4_in, flags4_ff;

   isp_pkg::iter_type st_in, st5_ff;

   assign pa[0] = item.pos_a_x;
   assign pa[1] = item.pos_a_y;
   assign pa[2] = item.pos_a_z;
   assign pb[0] = item.pos_b_x;
   assign pb[1] = item.pos_b_y;
   assign pb[2] = item.pos_b_z;

   assign valid_in = {valid_ff[3:0], in_valid};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_in[i] = $signed({pa[i][31], pa[i]}) - $signed({pb[i][31], pb[i]});
      end
      flags1_in.act  = enable & (item.free_a | item.free_b);
      flags1_in.zero = 1'b0;
      flags1_in.fa   = item.free_a;
      flags1_in.fb   = item.free_b;
      flags1_in.sneg = strength[31];
      for (int i = 0; i < 3; i++) begin
         flags1_in.negd[i] = d_in[i][32];
      end
      smag_in = strength[31] ? (~strength + 32'd1) : strength;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sqf[i]  = d1_ff[i] * d1_ff[i];
         sq_in[i] = sqf[i][64:0];
         u_in[i]  = d1_ff[i][32] ? (~d1_ff[i] + 33'd1) : d1_ff[i];
      end
      pm_in = {32'd0, smag1_ff} * {32'd0, ma1_ff};
      md_in = {32'd0, min1_ff} * {32'd0, min1_ff};
   end

   always_comb begin
      d2_in = {1'b0, sq2_ff[0]} + {1'b0, sq2_ff[1]} + {1'b0, sq2_ff[2]};
      e_in  = u2_ff[0][32] | u2_ff[0][31] | u2_ff[1][32] | u2_ff[1][31]
            | u2_ff[2][32] | u2_ff[2][31];
      for (int i = 0; i < 3; i++) begin
         v_in[i] = e_in ? u2_ff[i][32:1] : u2_ff[i][31:0];
      end
      pl_in = {32'd0, pm2_ff[31:0]} * {32'd0, mb2_ff};
      ph_in = {32'd0, pm2_ff[63:32]} * {32'd0, mb2_ff};
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vsq_in[i] = {32'd0, v3_ff[i]} * {32'd0, v3_ff[i]};
      end
      c_in = (d23_ff < {2'b00, md3_ff}) ? {2'b00, md3_ff} : d23_ff;
      p_full = {ph3_ff, 32'd0} + {32'd0, pl3_ff};
      p_in   = p_full[94:0];
      flags4_in      = flags3_ff;
      flags4_in.zero = (d23_ff == 66'd0);
   end

   always_comb begin
      st_in.flags = flags4_ff;
      st_in.rem   = {35'd0, p4_ff[94:64]};
      st_in.num   = p4_ff[63:0];
      st_in.c     = c4_ff;
      st_in.q     = '0;
      st_in.x     = vsq4_ff[0] + vsq4_ff[1] + vsq4_ff[2];
      st_in.srem  = '0;
      st_in.root  = '0;
      for (int i = 0; i < 3; i++) begin
         st_in.v[i] = v4_ff[i];
      end
      st_in.urem  = '0;
      st_in.uq    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (move) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         for (int i = 0; i < 3; i++) begin
            d1_ff[i]   <= d_in[i];
            sq2_ff[i]  <= sq_in[i];
            u2_ff[i]   <= u_in[i];
            v3_ff[i]   <= v_in[i];
            vsq4_ff[i] <= vsq_in[i];
            v4_ff[i]   <= v3_ff[i];
         end
         flags1_ff <= flags1_in;
         smag1_ff  <= smag_in;
         ma1_ff    <= item.mass_a;
         mb1_ff    <= item.mass_b;
         min1_ff   <= min_distance;
         pm2_ff    <= pm_in;
         md2_ff    <= md_in;
         mb2_ff    <= mb1_ff;
         flags2_ff <= flags1_ff;
         d23_ff    <= d2_in;
         pl3_ff    <= pl_in;
         ph3_ff    <= ph_in;
         md3_ff    <= md2_ff;
         flags3_ff <= flags2_ff;
         c4_ff     <= c_in;
         p4_ff     <= p_in;
         flags4_ff <= flags4_in;
         st5_ff    <= st_in;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_st    = st5_ff;

endmodule

`default_nettype wire

@@ rtl/core/isp_iter.sv @@
`default_nettype none

module isp_iter (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               move,
   input  wire logic               in_valid,
   input  wire isp_pkg::iter_type  in_st,
   output logic                    out_valid,
   output isp_pkg::iter_type       out_st
);

   localparam int N = isp_pkg::IterStages;

   logic [N-1:0]      valid_ff;
   isp_pkg::iter_type st_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      isp_pkg::iter_type cur;
      isp_pkg::iter_type nx;
      logic [66:0] rem2;
      logic        ge;
      logic [35:0] srem2;
      logic [35:0] strial;
      logic        sge;
      logic [32:0] urem2 [3];
      logic        uge [3];

      if (k == 0) begin : g_first
         assign cur = in_st;
      end else begin : g_next
         assign cur = st_ff[k-1];
      end

      always_comb begin
         nx = cur;
         rem2 = {cur.rem, cur.num[63]};
         ge   = rem2 >= {1'b0, cur.c};
         nx.rem = ge ? 66'(rem2 - {1'b0, cur.c}) : rem2[65:0];
         nx.q   = {cur.q[62:0], ge};
         nx.num = {cur.num[62:0], 1'b0};

         srem2  = {cur.srem, cur.x[63:62]};
         strial = {2'b00, cur.root, 2'b01};
         sge    = srem2 >= strial;
         for (int i = 0; i < 3; i++) begin
            urem2[i] = {cur.urem[i], 1'b0};
            uge[i]   = 1'b0;
         end

         if (k < isp_pkg::SqrtSteps) begin
            nx.srem = sge ? 34'(srem2 - strial) : srem2[33:0];
            nx.root = {cur.root[30:0], sge};
            nx.x    = {cur.x[61:0], 2'b00};
         end else if (k == isp_pkg::SqrtSteps) begin
            for (int i = 0; i < 3; i++) begin
               uge[i]     = cur.v[i] >= cur.root;
               nx.urem[i] = uge[i] ? (cur.v[i] - cur.root) : cur.v[i];
               nx.uq[i]   = {30'd0, uge[i]};
            end
         end else if (k <= isp_pkg::SqrtSteps + isp_pkg::UnitSteps) begin
            for (int i = 0; i < 3; i++) begin
               uge[i]     = urem2[i] >= {1'b0, cur.root};
               nx.urem[i] = uge[i] ? 32'(urem2[i] - {1'b0, cur.root}) : urem2[i][31:0];
               nx.uq[i]   = {cur.uq[i][29:0], uge[i]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (move) begin
            st_ff[k] <= nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (move) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_st    = st_ff[N-1];

endmodule

`default_nettype wire

@@ rtl/core/isp_back.sv @@
`default_nettype none

module isp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               move,
   input  wire logic               in_valid,
   input  wire isp_pkg::iter_type  in_st,
   output logic                    out_valid,
   output isp_pkg::result_type     out_res
);

   logic [2:0] valid_ff;

   logic [62:0] g_in;
   logic [62:0] glo_in [3];
   logic [62:0] glo1_ff [3];
   logic [61:0] ghi_in [3];
   logic [61:0] ghi1_ff [3];
   isp_pkg::flags_type flags1_ff, flags2_ff;

   logic [93:0] prod [3];
   logic [63:0] mag_in [3];
   logic [63:0] mag2_ff [3];

   isp_pkg::result_type res_in, res_ff;
   logic [31:0] val_a [3];
   logic [31:0] val_b [3];
   logic        sat_a [3];
   logic        sat_b [3];

   always_comb begin
      g_in = in_st.q[63] ? isp_pkg::G_CAP : in_st.q[62:0];
      for (int i = 0; i < 3; i++) begin
         glo_in[i] = {31'd0, g_in[31:0]} * {32'd0, in_st.uq[i]};
         ghi_in[i] = {31'd0, g_in[62:32]} * {31'd0, in_st.uq[i]};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod[i]   = {ghi1_ff[i], 32'd0} + {31'd0, glo1_ff[i]};
         mag_in[i] = (flags1_ff.act && !flags1_ff.zero) ? prod[i][93:30] : 64'd0;
      end
   end

   always_comb begin
      logic negb;
      logic ovp;
      logic ovn;
      logic [31:0] pos_v;
      logic [31:0] neg_v;
      for (int i = 0; i < 3; i++) begin
         negb  = flags2_ff.sneg ^ flags2_ff.negd[i];
         ovp   = |mag2_ff[i][63:31];
         ovn   = (|mag2_ff[i][63:32]) | (mag2_ff[i][31] & (|mag2_ff[i][30:0]));
         pos_v = ovp ? isp_pkg::SAT_POS : mag2_ff[i][31:0];
         neg_v = ovn ? isp_pkg::SAT_NEG : (~mag2_ff[i][31:0] + 32'd1);
         val_b[i] = flags2_ff.fb ? (negb ? neg_v : pos_v) : 32'd0;
         sat_b[i] = flags2_ff.fb & (negb ? ovn : ovp);
         val_a[i] = flags2_ff.fa ? (negb ? pos_v : neg_v) : 32'd0;
         sat_a[i] = flags2_ff.fa & (negb ? ovp : ovn);
      end
      res_in.pad       = '0;
      res_in.active    = flags2_ff.act;
      res_in.saturated = sat_a[0] | sat_a[1] | sat_a[2] | sat_b[0] | sat_b[1] | sat_b[2];
      res_in.push_a_x  = val_a[0];
      res_in.push_a_y  = val_a[1];
      res_in.push_a_z  = val_a[2];
      res_in.push_b_x  = val_b[0];
      res_in.push_b_y  = val_b[1];
      res_in.push_b_z  = val_b[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (move) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         for (int i = 0; i < 3; i++) begin
            glo1_ff[i] <= glo_in[i];
            ghi1_ff[i] <= ghi_in[i];
            mag2_ff[i] <= mag_in[i];
         end
         flags1_ff <= in_st.flags;
         flags2_ff <= flags1_ff;
         res_ff    <= res_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_res   = res_ff;

   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !res_ff.active |-> res_ff.push_a_x == 32'd0 && res_ff.push_a_y == 32'd0
         && res_ff.push_a_z == 32'd0 && res_ff.push_b_x == 32'd0
         && res_ff.push_b_y == 32'd0 && res_ff.push_b_z == 32'd0 && !res_ff.saturated)
      else $error("inactive item carries nonzero force");

   a_opposite: assert property (@(posedge clock) disable iff (reset)
      out_valid && !res_ff.saturated && res_ff.push_a_x != 32'd0 && res_ff.push_b_x != 32'd0
      |-> res_ff.push_a_x == (~res_ff.push_b_x + 32'd1))
      else $error("forces on the two particles are not opposite");

   a_sat_extreme: assert property (@(posedge clock) disable iff (reset)
      out_valid && res_ff.saturated |->
         res_ff.push_a_x == isp_pkg::SAT_POS || res_ff.push_a_x == isp_pkg::SAT_NEG
         || res_ff.push_a_y == isp_pkg::SAT_POS || res_ff.push_a_y == isp_pkg::SAT_NEG
         || res_ff.push_a_z == isp_pkg::SAT_POS || res_ff.push_a_z == isp_pkg::SAT_NEG
         || res_ff.push_b_x == isp_pkg::SAT_POS || res_ff.push_b_x == isp_pkg::SAT_NEG
         || res_ff.push_b_y == isp_pkg::SAT_POS || res_ff.push_b_y == isp_pkg::SAT_NEG
         || res_ff.push_b_z == isp_pkg::SAT_POS || res_ff.push_b_z == isp_pkg::SAT_NEG)
      else $error("saturation flagged without a clamped component");

endmodule

`default_nettype wire

@@ rtl/core/inverse_square_pair_force.sv @@
// An accepted item passes through the front, quotient and back pipelines to its result on rsp_tvalid.
// Throughput: one item per cycle while the output is not stalled; the 64-stage quotient pipeline is most of the depth.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset is synchronous and active high; it clears all valid bits and loads the
// configuration registers with strength 1.0, minimum distance 1.0 and enable set.
`default_nettype none

module inverse_square_pair_force (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z, mass_a, mass_b,
   // free_a, free_b, then zero padding.
   input  wire logic [263:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // push_a_x, push_a_y, push_a_z, push_b_x, push_b_y, push_b_z, active,
   // saturated, then zero padding.
   output logic [199:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   logic move;
   logic [31:0] strength_ff, min_distance_ff;
   logic        enable_ff;

   logic              front_valid, iter_valid;
   isp_pkg::iter_type front_st, iter_st;
   isp_pkg::item_type   item;
   isp_pkg::result_type res;

   assign move       = !rsp_tvalid || rsp_tready;
   assign req_tready = move;
   assign csr_ready  = 1'b1;
   assign item       = req_tdata;
   assign rsp_tdata  = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff     <= isp_pkg::STRENGTH_RESET;
         min_distance_ff <= isp_pkg::MIN_DISTANCE_RESET;
         enable_ff       <= isp_pkg::ENABLE_RESET;
      end else if (csr_valid) begin
         unique case (isp_pkg::csr_index_type'(csr_index))
            isp_pkg::CSR_STRENGTH: begin
               strength_ff <= csr_data;
            end
            isp_pkg::CSR_MIN_DISTANCE: begin
               min_distance_ff <= csr_data;
            end
            isp_pkg::CSR_ENABLE: begin
               enable_ff <= csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   isp_front u_front (
      .clock        (clock),
      .reset        (reset),
      .move         (move),
      .in_valid     (req_tvalid),
      .item         (item),
      .strength     (strength_ff),
      .min_distance (min_distance_ff),
      .enable       (enable_ff),
      .out_valid    (front_valid),
      .out_st       (front_st)
   );

   isp_iter u_iter (
      .clock     (clock),
      .reset     (reset),
      .move      (move),
      .in_valid  (front_valid),
      .in_st     (front_st),
      .out_valid (iter_valid),
      .out_st    (iter_st)
   );

   isp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .move      (move),
      .in_valid  (iter_valid),
      .in_st     (iter_st),
      .out_valid (rsp_tvalid),
      .out_res   (res)
   );

endmodule

`default_nettype wire

@@ tb/sv/tb_inverse_square_pair_force.sv @@
`default_nettype none

module tb_inverse_square_pair_force;
   import isp_pkg::*;

   class force_scoreboard;
      logic [31:0] strength;
      logic [31:0] min_distance;
      logic        enable;
      result_type  expected_forces[$];
      int          errors;

      function new();
         strength     = STRENGTH_RESET;
         min_distance = MIN_DISTANCE_RESET;
         enable       = ENABLE_RESET;
         errors       = 0;
      endfunction

      function automatic logic [63:0] int_sqrt(logic [63:0] x);
         logic [63:0]  res;
         logic [63:0]  t;
         res = 0;
         for (int b = 31; b >= 0; b--) begin
            t = res | (64'd1 << b);
            if (128'(t) * 128'(t) <= 128'(x)) res = t;
         end
         return res;
      endfunction

      function automatic logic [31:0] clamp_signed(logic [63:0] mag, logic big, logic neg,
                                                   inout logic sat);
         if (!neg) begin
            if (big || mag > 64'h7FFF_FFFF) begin
               sat = 1'b1;
               return SAT_POS;
            end
            return mag[31:0];
         end
         if (big || mag > 64'h8000_0000) begin
            sat = 1'b1;
            return SAT_NEG;
         end
         return 32'd0 - mag[31:0];
      endfunction

      function automatic result_type pair_force(item_type it);
         result_type        r;
         logic              act, sat, sneg, e, negb;
         logic [31:0]       smag;
         logic [31:0]       pa[3];
         logic [31:0]       pb[3];
         logic signed [32:0] d;
         logic [32:0]       u[3];
         logic              negd[3];
         logic              big[3];
         logic [63:0]       mag[3];
         logic [63:0]       v[3];
         logic [63:0]       d2v, len, unit;
         logic [127:0]      d2, md2, c, p, g, prod;
         logic [31:0]       push_a[3];
         logic [31:0]       push_b[3];
         r = '0;
         pa[0] = it.pos_a_x; pa[1] = it.pos_a_y; pa[2] = it.pos_a_z;
         pb[0] = it.pos_b_x; pb[1] = it.pos_b_y; pb[2] = it.pos_b_z;
         act = enable && (it.free_a || it.free_b);
         sat = 1'b0;
         sneg = strength[31];
         smag = sneg ? 32'd0 - strength : strength;
         for (int i = 0; i < 3; i++) begin
            mag[i] = 0; big[i] = 0; push_a[i] = 0; push_b[i] = 0; negd[i] = 0;
         end
         if (act) begin
            d2 = 0;
            for (int i = 0; i < 3; i++) begin
               d = $signed({pa[i][31], pa[i]}) - $signed({pb[i][31], pb[i]});
               negd[i] = d < 0;
               u[i] = negd[i] ? 33'd0 - d : d;
               d2 = d2 + 128'(u[i]) * 128'(u[i]);
            end
            if (d2 != 0) begin
               md2 = 128'(min_distance) * 128'(min_distance);
               c = (d2 < md2) ? md2 : d2;
               p = 128'(smag) * 128'(it.mass_a) * 128'(it.mass_b);
               g = p / c;
               if (g > 128'h7FFF_FFFF_FFFF_FFFF) g = 128'h7FFF_FFFF_FFFF_FFFF;
               e = 0;
               for (int i = 0; i < 3; i++)
                  if (u[i] >= 33'h8000_0000) e = 1;
               d2v = 0;
               for (int i = 0; i < 3; i++) begin
                  v[i] = 64'(u[i]) >> e;
                  d2v = d2v + v[i] * v[i];
               end
               len = int_sqrt(d2v);
               for (int i = 0; i < 3; i++) begin
                  unit = (v[i] << 30) / len;
                  if (unit > 64'd1 << 30) unit = 64'd1 << 30;
                  prod = g * 128'(unit);
                  big[i] = |prod[127:94];
                  mag[i] = prod[93:30];
               end
            end
            for (int i = 0; i < 3; i++) begin
               negb = sneg != negd[i];
               if (mag[i] != 0 || big[i]) begin
                  if (it.free_b) push_b[i] = clamp_signed(mag[i], big[i], negb, sat);
                  if (it.free_a) push_a[i] = clamp_signed(mag[i], big[i], !negb, sat);
               end
            end
         end
         r.push_a_x = push_a[0]; r.push_a_y = push_a[1]; r.push_a_z = push_a[2];
         r.push_b_x = push_b[0]; r.push_b_y = push_b[1]; r.push_b_z = push_b[2];
         r.active = act;
         r.saturated = sat;
         return r;
      endfunction

      function void note_item(item_type it);
         expected_forces.push_back(pair_force(it));
      endfunction

      function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %h, actual %h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(result_type got);
         result_type exp_r;
         if (expected_forces.size() == 0) begin
            $error("result item with no expectation waiting");
            errors++;
            return;
         end
         exp_r = expected_forces.pop_front();
         compare("push_a_x", exp_r.push_a_x, got.push_a_x);
         compare("push_a_y", exp_r.push_a_y, got.push_a_y);
         compare("push_a_z", exp_r.push_a_z, got.push_a_z);
         compare("push_b_x", exp_r.push_b_x, got.push_b_x);
         compare("push_b_y", exp_r.push_b_y, got.push_b_y);
         compare("push_b_z", exp_r.push_b_z, got.push_b_z);
         compare("active", 32'(exp_r.active), 32'(got.active));
         compare("saturated", 32'(exp_r.saturated), 32'(got.saturated));
      endfunction
   endclass

   logic           clock = 0;
   logic           reset = 1;
   logic           req_tvalid = 0;
   logic           req_tready;
   logic [263:0]   req_tdata = '0;
   logic           rsp_tvalid;
   logic           rsp_tready = 0;
   logic [199:0]   rsp_tdata;
   logic           csr_valid = 0;
   logic           csr_ready;
   logic [1:0]     csr_index = CSR_STRENGTH;
   logic [31:0]    csr_data = '0;

   force_scoreboard sb = new();
   int  idle_cycles = 0;
   int  burst_left = 0;
   bit  long_hold = 0;

   always #5 clock = ~clock;

   inverse_square_pair_force dut (.*);

   always @(posedge clock) begin
      if (req_tvalid && req_tready) sb.note_item(item_type'(req_tdata));
      if (rsp_tvalid && rsp_tready) sb.check_result(result_type'(rsp_tdata));
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_STRENGTH:     sb.strength = csr_data;
            CSR_MIN_DISTANCE: sb.min_distance = csr_data;
            CSR_ENABLE:       sb.enable = csr_data[0];
            default: ;
         endcase
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 3000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // The receiver mixes always ready, random stalls, a fixed pattern, a long hold.
   initial begin
      int mode;
      int seg;
      @(negedge reset);
      forever begin
         if (long_hold) begin
            rsp_tready <= 0;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         mode = $urandom_range(0, 2);
         seg = $urandom_range(8, 40);
         for (int k = 0; k < seg; k++) begin
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= (k % 4) != 3;
            endcase
            @(posedge clock);
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_item(item_type it);
      req_tdata <= it;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.expected_forces.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] strength, logic [31:0] min_distance, logic enable);
      write_csr(CSR_STRENGTH, strength);
      write_csr(CSR_MIN_DISTANCE, min_distance);
      write_csr(CSR_ENABLE, {31'(0), enable});
      csr_valid <= 0;
   endtask

   function automatic item_type make_item(int kind);
      item_type    it;
      logic [31:0] delta;
      it = '0;
      it.pos_a_x = $urandom(); it.pos_a_y = $urandom(); it.pos_a_z = $urandom();
      it.free_a = $urandom_range(0, 1);
      it.free_b = $urandom_range(0, 1);
      if (kind < 6) begin
         delta = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
         it.pos_b_x = it.pos_a_x + delta;
         delta = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
         it.pos_b_y = it.pos_a_y + delta;
         delta = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
         it.pos_b_z = it.pos_a_z + delta;
         it.mass_a = $urandom_range(0, 1 << 20);
         it.mass_b = $urandom_range(0, 1 << 20);
      end else if (kind == 6) begin
         it.pos_b_x = it.pos_a_x; it.pos_b_y = it.pos_a_y; it.pos_b_z = it.pos_a_z;
         it.mass_a = $urandom(); it.mass_b = $urandom();
      end else begin
         it.pos_b_x = $urandom(); it.pos_b_y = $urandom(); it.pos_b_z = $urandom();
         it.mass_a = $urandom(); it.mass_b = $urandom();
      end
      return it;
   endfunction

   initial begin
      item_type it;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      configure(32'd65536, 32'd65536, 1'b1);
      for (int k = 0; k < 24; k++) begin
         it = '0;
         it.free_a = k[0] | k[3];
         it.free_b = k[1] | k[3];
         it.mass_a = 32'd65536;
         it.mass_b = 32'd65536;
         case (k % 8)
            0: it.pos_a_x = 32'd65536;
            1: begin it.pos_a_x = 32'h7FFF_FFFF; it.pos_b_x = 32'h8000_0000; end
            2: begin it.pos_a_y = 32'h8000_0000; it.pos_b_y = 32'h7FFF_FFFF;
                     it.pos_a_z = 32'h8000_0000; it.pos_b_x = 32'h7FFF_FFFF; end
            3: begin it.mass_a = '1; it.mass_b = '1; it.pos_a_z = 32'd1; end
            4: it.pos_b_y = 32'd16;
            5: begin it.mass_a = 0; it.pos_a_x = 32'd3 << 16; end
            6: begin it.pos_a_x = 32'd12345; it.pos_b_x = 32'd12345; end
            default: begin it.pos_a_x = 32'h0001_8000; it.pos_a_y = 32'hFFFF_0000;
                           it.pos_b_z = 32'h0002_0000; it.mass_b = '1; end
         endcase
         send_item(it);
      end
      drain();

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: configure(32'd65536, 32'd65536, 1'b1);
            1: configure(32'hFFFF_0000, 32'd0, 1'b1);
            2: configure(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
            3: configure(32'h8000_0000, 32'd0, 1'b1);
            4: configure($urandom(), $urandom_range(0, 1 << 18), 1'b1);
            5: configure($urandom(), $urandom(), 1'b0);
            default: configure($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 17), 1'b1);
         endcase
         if (ph == 2) long_hold = 1;
         for (int k = 0; k < 100; k++) send_item(make_item($urandom_range(0, 9)));
         drain();
      end

      if (sb.errors == 0 && sb.expected_forces.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

`default_nettype wire
